// ----- rtl/core/mtep_pkg.sv -----
package mtep_pkg;

  localparam int unsigned MAX_DELTA_BYTES = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned BPM_W = 26;
  localparam logic [BPM_W-1:0] TEMPO_DIVIDEND = 26'd60000000;

  localparam logic [7:0] META_TEXT = 8'h01;
  localparam logic [7:0] META_NAME = 8'h03;
  localparam logic [7:0] META_END = 8'h2f;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_TSIG = 8'h58;

  typedef enum logic [3:0] {
    KIND_HEADER = 4'd0,
    KIND_DELTA = 4'd1,
    KIND_STRAY = 4'd2,
    KIND_NOTE_OFF = 4'd3,
    KIND_NOTE_ON = 4'd4,
    KIND_CONTROL = 4'd5,
    KIND_PROGRAM = 4'd6,
    KIND_TEXT = 4'd7,
    KIND_NAME = 4'd8,
    KIND_END = 4'd9,
    KIND_TEMPO = 4'd10,
    KIND_TSIG = 4'd11,
    KIND_META_UNK = 4'd12,
    KIND_STATUS_UNK = 4'd13
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_TEMPO_ZERO = 2'd1,
    ERR_DELTA_LONG = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    PH_HEADER, PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_MTYPE, PH_MLEN, PH_MBODY
  } phase_e;

  typedef enum logic [1:0] {
    BK_IDLE, BK_DIV, BK_WAIT
  } back_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [3:0]  channel;
    logic [31:0] value_a;
    logic [7:0]  value_b;
    logic [8:0]  byte_count;
    logic [25:0] tempo_bpm;
    logic [7:0]  sig_numerator;
    logic [15:0] sig_denominator;
    logic [7:0]  meta_length;
    logic [1:0]  error_code;
    logic [31:0] start_offset;
  } out_t;

  // Queue entry: a classified unit with the raw tempo still to be divided.
  typedef struct packed {
    logic [3:0]  event_kind;
    logic [3:0]  channel;
    logic [31:0] value_a;
    logic [7:0]  value_b;
    logic [8:0]  byte_count;
    logic [23:0] tempo_micros;
    logic [7:0]  sig_numerator;
    logic [15:0] sig_denominator;
    logic [7:0]  meta_length;
    logic [1:0]  error_code;
    logic [31:0] start_offset;
  } evt_t;

endpackage

// ----- rtl/core/mtep_front.sv -----
module mtep_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  mtep_pkg::in_t in_i,
  output logic          push_o,
  output mtep_pkg::evt_t evt_o
);
  import mtep_pkg::*;

  phase_e      ph_q, ph_d, ph_c;
  logic [8:0]  sub_q, sub_d, sub_c;
  logic [31:0] acc_q, acc_d, acc_c;
  logic [7:0]  st_q, st_d, st_c;
  logic [7:0]  fd_q, fd_d, fd_c;
  logic [7:0]  mt_q, mt_d, mt_c;
  logic [7:0]  ml_q, ml_d, ml_c;
  logic [23:0] us_q, us_d, us_c;
  logic [7:0]  num_q, num_d, num_c;
  logic [7:0]  exp_q, exp_d, exp_c;
  logic [31:0] off_q, off_d, off_c;
  logic [31:0] ust_q, ust_d, ust_c;
  logic        fin_q, fin_d, fin_c;
  logic [7:0]  b;
  logic        res;
  logic        meta_done;
  evt_t        e;
  logic [8:0]  sub_inc;

  always_comb begin
    b = in_i.data_byte;
    // A track start clears everything before the byte is taken.
    ph_c = in_i.track_start ? PH_HEADER : ph_q;
    sub_c = in_i.track_start ? '0 : sub_q;
    acc_c = in_i.track_start ? '0 : acc_q;
    st_c = in_i.track_start ? '0 : st_q;
    fd_c = in_i.track_start ? '0 : fd_q;
    mt_c = in_i.track_start ? '0 : mt_q;
    ml_c = in_i.track_start ? '0 : ml_q;
    us_c = in_i.track_start ? '0 : us_q;
    num_c = in_i.track_start ? '0 : num_q;
    exp_c = in_i.track_start ? '0 : exp_q;
    off_c = in_i.track_start ? '0 : off_q;
    ust_c = in_i.track_start ? '0 : ust_q;
    fin_c = in_i.track_start ? 1'b0 : fin_q;

    ph_d = ph_c; sub_d = sub_c; acc_d = acc_c; st_d = st_c; fd_d = fd_c;
    mt_d = mt_c; ml_d = ml_c; us_d = us_c; num_d = num_c; exp_d = exp_c;
    ust_d = ust_c; fin_d = fin_c;
    off_d = off_c + 32'd1;
    sub_inc = sub_c + 9'd1;
    res = 1'b0;
    meta_done = 1'b0;
    e = '0;

    if (!fin_c) begin
      case (ph_c)
        PH_HEADER: begin
          if (sub_c == '0) begin
            ust_d = off_c;
            acc_d = '0;
          end
          if (sub_c >= 9'd4) acc_d = {acc_d[23:0], b};
          sub_d = sub_inc;
          if (sub_inc >= 9'd8) begin
            res = 1'b1;
            e.event_kind = KIND_HEADER;
            e.value_a = acc_d;
            e.byte_count = 9'd8;
            ph_d = PH_DELTA;
            sub_d = '0;
          end
        end
        PH_DELTA: begin
          if (sub_c == '0) begin
            ust_d = off_c;
            acc_d = '0;
          end
          acc_d = {acc_d[24:0], b[6:0]};
          sub_d = sub_inc;
          if (!b[7] || sub_inc >= 9'(MAX_DELTA_BYTES)) begin
            res = 1'b1;
            e.event_kind = KIND_DELTA;
            e.value_a = acc_d;
            e.byte_count = sub_inc;
            e.error_code = b[7] ? ERR_DELTA_LONG : ERR_NONE;
            ph_d = PH_STATUS;
            sub_d = '0;
          end
        end
        PH_STATUS: begin
          ust_d = off_c;
          if (!b[7]) begin
            res = 1'b1;
            e.event_kind = KIND_STRAY;
            e.value_a = {24'd0, b};
            e.byte_count = 9'd1;
          end else if (b <= 8'hdf) begin
            st_d = b;
            ph_d = PH_DATA1;
          end else if (b == 8'hff) begin
            st_d = b;
            us_d = '0;
            num_d = '0;
            exp_d = '0;
            ph_d = PH_MTYPE;
          end else begin
            res = 1'b1;
            e.event_kind = KIND_STATUS_UNK;
            e.value_a = {24'd0, b};
            e.byte_count = 9'd1;
            ph_d = PH_DELTA;
            sub_d = '0;
          end
        end
        PH_DATA1: begin
          if (st_c >= 8'hc0) begin
            res = 1'b1;
            e.event_kind = KIND_PROGRAM;
            e.channel = st_c[3:0];
            e.value_a = {24'd0, b};
            e.byte_count = 9'd2;
            ph_d = PH_DELTA;
            sub_d = '0;
          end else begin
            fd_d = b;
            ph_d = PH_DATA2;
          end
        end
        PH_DATA2: begin
          res = 1'b1;
          if (st_c >= 8'hb0) e.event_kind = KIND_CONTROL;
          else if (st_c[7:4] == 4'h9) e.event_kind = KIND_NOTE_ON;
          else e.event_kind = KIND_NOTE_OFF;
          e.channel = st_c[3:0];
          e.value_a = {24'd0, fd_c};
          e.value_b = b;
          e.byte_count = 9'd3;
          ph_d = PH_DELTA;
          sub_d = '0;
        end
        PH_MTYPE: begin
          mt_d = b;
          ph_d = PH_MLEN;
        end
        PH_MLEN: begin
          ml_d = b;
          sub_d = '0;
          if (b == '0) meta_done = 1'b1;
          else ph_d = PH_MBODY;
        end
        PH_MBODY: begin
          if (sub_c == 9'd0) begin
            us_d[23:16] = us_c[23:16] | b;
            num_d = b;
          end else if (sub_c == 9'd1) begin
            us_d[15:8] = us_c[15:8] | b;
            exp_d = b;
          end else if (sub_c == 9'd2) begin
            us_d[7:0] = us_c[7:0] | b;
          end
          sub_d = sub_inc;
          if (sub_inc >= {1'b0, ml_c}) meta_done = 1'b1;
        end
        default: begin
          ph_d = PH_DELTA;
          sub_d = '0;
        end
      endcase

      if (meta_done) begin
        res = 1'b1;
        e.value_a = {24'd0, mt_d};
        e.byte_count = 9'd3 + {1'b0, ml_d};
        e.meta_length = ml_d;
        if (mt_d == META_TEXT) e.event_kind = KIND_TEXT;
        else if (mt_d == META_NAME) e.event_kind = KIND_NAME;
        else if (mt_d == META_END) begin
          e.event_kind = KIND_END;
          fin_d = 1'b1;
        end else if (mt_d == META_TEMPO) begin
          e.event_kind = KIND_TEMPO;
          e.tempo_micros = us_d;
          e.error_code = (us_d == '0) ? ERR_TEMPO_ZERO : ERR_NONE;
        end else if (mt_d == META_TSIG) begin
          e.event_kind = KIND_TSIG;
          e.sig_numerator = num_d;
          e.sig_denominator = 16'd1 << ((exp_d > 8'd15) ? 4'd15 : exp_d[3:0]);
        end else e.event_kind = KIND_META_UNK;
        ph_d = PH_DELTA;
        sub_d = '0;
      end
    end
    e.start_offset = ust_d;
  end

  assign push_o = accept_i && res;
  assign evt_o = e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_HEADER; sub_q <= '0; acc_q <= '0; st_q <= '0; fd_q <= '0;
      mt_q <= '0; ml_q <= '0; us_q <= '0; num_q <= '0; exp_q <= '0;
      off_q <= '0; ust_q <= '0; fin_q <= 1'b0;
    end else if (accept_i) begin
      ph_q <= ph_d; sub_q <= sub_d; acc_q <= acc_d; st_q <= st_d; fd_q <= fd_d;
      mt_q <= mt_d; ml_q <= ml_d; us_q <= us_d; num_q <= num_d; exp_q <= exp_d;
      off_q <= off_d; ust_q <= ust_d; fin_q <= fin_d;
    end
  end

endmodule

// ----- rtl/core/mtep_fifo.sv -----
module mtep_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mtep_pkg::evt_t data_i,
  input  logic           pop_i,
  output mtep_pkg::evt_t data_o,
  output logic           full_o,
  output logic           empty_o
);
  import mtep_pkg::*;

  evt_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// ----- rtl/core/mtep_back.sv -----
module mtep_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mtep_pkg::evt_t evt_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mtep_pkg::out_t out_data_o
);
  import mtep_pkg::*;

  back_e       st_q, st_d;
  evt_t        hold_q, hold_d;
  logic [23:0] rem_q, rem_d;
  logic [BPM_W-1:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        ov_q, ov_d;
  out_t        od_q, od_d;
  logic        slot_free;
  logic        need_div;
  logic [24:0] trial;
  logic        ge;

  function automatic out_t to_out(evt_t e, logic [BPM_W-1:0] bpm);
    out_t o;
    o.event_kind = e.event_kind;
    o.channel = e.channel;
    o.value_a = e.value_a;
    o.value_b = e.value_b;
    o.byte_count = e.byte_count;
    o.tempo_bpm = bpm;
    o.sig_numerator = e.sig_numerator;
    o.sig_denominator = e.sig_denominator;
    o.meta_length = e.meta_length;
    o.error_code = e.error_code;
    o.start_offset = e.start_offset;
    return o;
  endfunction

  assign slot_free = !ov_q || !out_stall_i;
  assign need_div = (evt_i.event_kind == KIND_TEMPO) && (evt_i.error_code == ERR_NONE);
  // One quotient bit per cycle, most significant first.
  assign trial = {rem_q, TEMPO_DIVIDEND[5'(BPM_W-1) - cnt_q]};
  assign ge = trial >= {1'b0, hold_q.tempo_micros};

  always_comb begin
    st_d = st_q; hold_d = hold_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q;
    ov_d = ov_q && out_stall_i;
    od_d = od_q;
    pop_o = 1'b0;
    case (st_q)
      BK_IDLE: begin
        if (!empty_i && slot_free) begin
          pop_o = 1'b1;
          if (need_div) begin
            hold_d = evt_i;
            rem_d = '0;
            quo_d = '0;
            cnt_d = '0;
            st_d = BK_DIV;
          end else begin
            od_d = to_out(evt_i, '0);
            ov_d = 1'b1;
          end
        end
      end
      BK_DIV: begin
        rem_d = ge ? 24'(trial - {1'b0, hold_q.tempo_micros}) : trial[23:0];
        quo_d = {quo_q[BPM_W-2:0], ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(BPM_W-1)) st_d = BK_WAIT;
      end
      BK_WAIT: begin
        if (slot_free) begin
          od_d = to_out(hold_q, quo_q);
          ov_d = 1'b1;
          st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      ov_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    od_q <= od_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o = od_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> st_q == BK_IDLE) else $error("pop outside idle");
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BK_DIV && cnt_q == 5'(BPM_W-1)) |=> st_q == BK_WAIT)
    else $error("divider did not finish");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q) else $error("result dropped under stall");

endmodule

// ----- rtl/core/midi_track_event_parser_unit.sv -----
// MIDI track event parser.
// Input channel: one track byte per request on in_valid_i/in_data_i; an item
// is taken when in_valid_i is high and in_stall_o is low. track_start set on
// a byte restarts the parser at the chunk header with the offset cleared.
// Output channel: one record per finished unit (header, delta, event, meta)
// on out_valid_o/out_data_o, taken when out_stall_i is low.
// The front classifier pushes finished units into a four-entry queue and
// takes one byte per cycle while that queue is not full. The back end drains
// the queue into an output register: an ordinary unit is popped from the
// queue head and loaded there when the register is free or being taken.
// A tempo event with a nonzero value runs a bit-serial divider, and the
// back end pops nothing until it is done; the queue keeps the front going
// meanwhile and in_stall_o rises only when the queue is full.
// A stalled result holds in the output register; new results queue behind.
// Reset clears the parser to the header phase, empties the queue and drops
// any pending result.
module midi_track_event_parser_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mtep_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mtep_pkg::out_t out_data_o
);
  import mtep_pkg::*;

  logic accept, push, pop, full, empty;
  evt_t evt_push, evt_head;

  assign in_stall_o = full;
  assign accept = in_valid_i && !full;

  mtep_front u_front (
    .clk_i, .rst_ni, .accept_i(accept), .in_i(in_data_i),
    .push_o(push), .evt_o(evt_push)
  );

  mtep_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(evt_push), .pop_i(pop),
    .data_o(evt_head), .full_o(full), .empty_o(empty)
  );

  mtep_back u_back (
    .clk_i, .rst_ni, .evt_i(evt_head), .empty_i(empty), .pop_o(pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
